// ----- rtl/core/fir_filter_ring_buffer_top_assert.svh -----
// ----------------------------------------------------------------------------
// fir_filter_ring_buffer_top_assert.svh
// Assertion macros for the FIR filter block. Simulation builds get the
// checks; synthesis builds get empty macros.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_RING_BUFFER_TOP_ASSERT_SVH
`define FIR_FILTER_RING_BUFFER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define FRB_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// Condition must never be true outside reset
`define FRB_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define FRB_ASSERT(name, clk, rst_n, prop)
`define FRB_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ----- rtl/core/frb_pkg.sv -----
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types and constants of the FIR filter: field widths, operation
// codes, fixed-point scaling and the MAC control bundle.
// ----------------------------------------------------------------------------
package frb_pkg;

	// Field widths
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 18;
	localparam int TAP_IDX_W = 5;
	localparam int OUT_W     = 25;

	// Unsigned sample widened by a sign bit, times signed coefficient
	localparam int PROD_W = SAMPLE_W + 1 + COEF_W;

	// Q20.14 products scaled to integer output units
	localparam int FRAC_SHIFT = 14;

	// Output saturation limits
	localparam longint OUT_MAX = 64'sd16777215;
	localparam longint OUT_MIN = -64'sd16777216;

	// Operation codes
	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// Control from the sequencer to the MAC, aligned with memory read data
	typedef struct packed {
		logic clear;   // start of a new output: zero the accumulator
		logic valid;   // read data holds one tap
		logic last;    // this is the final tap of the output
	} mac_ctl_t;

endpackage

// ----- rtl/core/fir_filter_ring_buffer_top.sv -----
// A filter transaction keeps the block busy from acceptance until its result
// is loaded into the output register; a coefficient load leaves it idle. The
// busy span is set by the single multiply-accumulate unit, which sees one tap
// per cycle from one read port on each memory, plus the read, product and
// accumulate registers, and grows while a full output register is not taken.
// The result waits there, so the next input is accepted while it is pending.
// ----------------------------------------------------------------------------
// fir_filter_ring_buffer_top
// Direct-form FIR filter over a sample ring kept in RAM. A filter transaction
// stores a sample and sweeps all taps through one MAC; a load transaction
// writes one coefficient.
// ----------------------------------------------------------------------------
module fir_filter_ring_buffer_top #(
	parameter int TAPS       = 31,
	parameter int RING_DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [frb_pkg::SAMPLE_W-1:0]        sample_value,
	input  logic [frb_pkg::TAP_IDX_W-1:0]       tap_index,
	input  logic signed [frb_pkg::COEF_W-1:0]   coef_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [frb_pkg::OUT_W-1:0]    filtered_value
);
	import frb_pkg::*;

	`include "fir_filter_ring_buffer_top_assert.svh"

	localparam int RA_W = $clog2(RING_DEPTH);
	localparam int CA_W = $clog2(TAPS);

	// Sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]              state_q;
	logic [RA_W-1:0]         ring_ptr_q;
	logic [RA_W-1:0]         rd_pos_q;
	logic [CA_W-1:0]         coef_cnt_q;
	logic                    issue_s1;
	logic                    last_s1;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] filtered_q;

	logic                    accept;
	logic                    filter_acc;
	logic                    load_acc;
	logic                    issue;
	logic                    out_load;
	logic [SAMPLE_W-1:0]     ring_rd_data;
	logic [COEF_W-1:0]       coef_rd_data;
	mac_ctl_t                mac_ctl;
	logic                    mac_done;
	logic signed [OUT_W-1:0] mac_result;

	// Input transaction decode
	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign filter_acc = accept && (opcode == OP_FILTER);
	assign load_acc   = accept && (opcode == OP_LOAD) && (32'(tap_index) < 32'(TAPS));
	assign issue      = (state_q == S_RUN);
	assign out_load   = (state_q == S_DRAIN) && mac_done && (!out_valid_q || out_ready);

	// Sample ring and coefficient store
	frb_mem #(
		.DEPTH (RING_DEPTH),
		.WIDTH (SAMPLE_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (filter_acc),
		.wr_addr (ring_ptr_q),
		.wr_data (sample_value),
		.rd_addr (rd_pos_q),
		.rd_data (ring_rd_data)
	);

	frb_mem #(
		.DEPTH (TAPS),
		.WIDTH (COEF_W)
	) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_acc),
		.wr_addr (CA_W'(tap_index)),
		.wr_data (coef_value),
		.rd_addr (coef_cnt_q),
		.rd_data (coef_rd_data)
	);

	// Sequencer: newest sample pairs with the last coefficient, walking back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ring_ptr_q <= '0;
			rd_pos_q   <= '0;
			coef_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (filter_acc) begin
						rd_pos_q   <= ring_ptr_q;
						coef_cnt_q <= CA_W'(TAPS - 1);
						ring_ptr_q <= (ring_ptr_q == RA_W'(RING_DEPTH - 1)) ?
							'0 : ring_ptr_q + 1'b1;
						state_q    <= S_RUN;
					end
				end
				S_RUN: begin
					rd_pos_q <= (rd_pos_q == '0) ?
						RA_W'(RING_DEPTH - 1) : rd_pos_q - 1'b1;
					if (coef_cnt_q == '0) begin
						state_q <= S_DRAIN;
					end else begin
						coef_cnt_q <= coef_cnt_q - 1'b1;
					end
				end
				S_DRAIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Control aligned with memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			issue_s1 <= issue;
			last_s1  <= issue && (coef_cnt_q == '0);
		end
	end

	assign mac_ctl = '{clear: filter_acc, valid: issue_s1, last: last_s1};

	frb_mac #(
		.TAPS (TAPS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.sample (ring_rd_data),
		.coef   ($signed(coef_rd_data)),
		.done   (mac_done),
		.result (mac_result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= mac_result;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = filtered_q;

	// Checks
	`FRB_ASSERT(a_start_sweep, clk, arst_n, filter_acc |=> (state_q == S_RUN) && (coef_cnt_q == CA_W'(TAPS - 1)))
	`FRB_ASSERT(a_sweep_end, clk, arst_n, (issue && coef_cnt_q == '0) |=> (state_q == S_DRAIN))
	`FRB_ASSERT_NEVER(a_no_overwrite, clk, arst_n, out_load && out_valid_q && !out_ready)
	`FRB_ASSERT_NEVER(a_done_in_sweep, clk, arst_n, (state_q == S_RUN) && mac_done)

endmodule

// ----- rtl/core/frb_mem.sv -----
// ----------------------------------------------------------------------------
// frb_mem
// Single-port-write, single-port-read synchronous RAM with a registered
// read. Per-entry valid flags make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module frb_mem #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] entry_vld_q;
	logic [WIDTH-1:0] rd_raw_q;
	logic             rd_vld_q;

	// Storage array and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	// Written-entry flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= entry_vld_q[rd_addr];
		end
	end

	// Entries never written since reset read as zero
	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

// ----- rtl/core/frb_mac.sv -----
// ----------------------------------------------------------------------------
// frb_mac
// Multiply-accumulate unit: one registered product per cycle, a running
// sum, and the final scaling (truncate toward zero) with saturation.
// ----------------------------------------------------------------------------
module frb_mac #(
	parameter int TAPS = 31
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  frb_pkg::mac_ctl_t                  ctl,
	input  logic [frb_pkg::SAMPLE_W-1:0]       sample,
	input  logic signed [frb_pkg::COEF_W-1:0]  coef,
	output logic                               done,
	output logic signed [frb_pkg::OUT_W-1:0]   result
);
	import frb_pkg::*;

	// Sum of TAPS products needs log2(TAPS) guard bits
	localparam int ACC_W = PROD_W + $clog2(TAPS);
	localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'((1 << FRAC_SHIFT) - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic                     last_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [ACC_W-1:0]  bias;
	logic signed [ACC_W-1:0]  biased;
	logic signed [ACC_W-1:0]  scaled;

	// Product stage
	always_ff @(posedge clk) begin
		prod_s2 <= $signed({1'b0, sample}) * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s2 <= ctl.valid;
			last_s2  <= ctl.valid & ctl.last;
		end
	end

	// Accumulator
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// Sum complete flag, held until the next output starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (ctl.clear) begin
			done_q <= 1'b0;
		end else if (valid_s2 && last_s2) begin
			done_q <= 1'b1;
		end
	end

	// Shift right toward zero: bias negative sums before the arithmetic shift
	always_comb begin
		bias   = acc_q[ACC_W-1] ? BIAS : '0;
		biased = acc_q + bias;
		scaled = biased >>> FRAC_SHIFT;
		if (scaled > SAT_HI) begin
			result = OUT_W'(SAT_HI);
		end else if (scaled < SAT_LO) begin
			result = OUT_W'(SAT_LO);
		end else begin
			result = OUT_W'(scaled);
		end
	end

	assign done = done_q;

endmodule

// ----- tb/tb_fir_filter_ring_buffer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_filter_ring_buffer_top
// Self-checking testbench for the 31-tap FIR filter. Coefficient loads and
// filter samples go in over a valid/ready channel with bursty idling, and the
// receiver stalls on its own pattern, once for a long stretch. A scoreboard
// keeps its own copy of the sample ring and coefficients and compares every
// filter output against its prediction.
// ----------------------------------------------------------------------------
module tb_fir_filter_ring_buffer_top;
	import frb_pkg::*;

	localparam int TAPS        = 31;
	localparam int RING_DEPTH  = 32;
	localparam int ITEM_TARGET = 1650;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_CAP  = 100;

	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [SAMPLE_W-1:0]      SAMPLE_FULL = '1;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic                        opcode;
	logic [SAMPLE_W-1:0]         sample_value;
	logic [TAP_IDX_W-1:0]        tap_index;
	logic signed [COEF_W-1:0]    coef_value;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [OUT_W-1:0]     filtered_value;

	fir_filter_ring_buffer_top #(
		.TAPS       (TAPS),
		.RING_DEPTH (RING_DEPTH)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.sample_value   (sample_value),
		.tap_index      (tap_index),
		.coef_value     (coef_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_value (filtered_value)
	);

	// Scoreboard: mirrors ring, coefficients and write pointer
	class fir_output_checker;
		logic [SAMPLE_W-1:0]      ring_mirror [RING_DEPTH];
		logic signed [COEF_W-1:0] coef_mirror [TAPS];
		int                       write_ptr;
		logic signed [OUT_W-1:0]  expected_outputs [$];
		int                       errors;

		function new();
			foreach (ring_mirror[i]) ring_mirror[i] = '0;
			foreach (coef_mirror[i]) coef_mirror[i] = '0;
			write_ptr = 0;
			errors    = 0;
		endfunction

		// Store the sample, then sum the taps newest-first against coef[TAPS-1-k]
		function logic signed [OUT_W-1:0] filter_output(logic [SAMPLE_W-1:0] s);
			longint acc;
			longint y;
			int     newest;
			int     pos;
			ring_mirror[write_ptr] = s;
			write_ptr = (write_ptr + 1) % RING_DEPTH;
			newest = (write_ptr + RING_DEPTH - 1) % RING_DEPTH;
			acc = 0;
			for (int k = 0; k < TAPS; k++) begin
				pos = (newest + RING_DEPTH - (k % RING_DEPTH)) % RING_DEPTH;
				acc += longint'(coef_mirror[TAPS-1-k]) * longint'(ring_mirror[pos]);
			end
			// shift the magnitude so the result truncates toward zero
			if (acc < 0)
				y = -((-acc) >>> FRAC_SHIFT);
			else
				y = acc >>> FRAC_SHIFT;
			if (y > OUT_MAX)
				y = OUT_MAX;
			if (y < OUT_MIN)
				y = OUT_MIN;
			return y[OUT_W-1:0];
		endfunction

		function void note_input(logic op, logic [SAMPLE_W-1:0] s,
				logic [TAP_IDX_W-1:0] t, logic signed [COEF_W-1:0] c);
			if (op == OP_LOAD) begin
				// slot past the last tap is dropped
				if (t < TAPS)
					coef_mirror[t] = c;
			end else begin
				expected_outputs.push_back(filter_output(s));
			end
		endfunction

		function void check_output(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] want;
			if (expected_outputs.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected output, expected none, actual %0d",
						$time, got);
				return;
			end
			want = expected_outputs.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: filtered_value mismatch, expected %0d, actual %0d",
						$time, want, got);
			end
		endfunction

		function int pending();
			return expected_outputs.size();
		endfunction
	endclass

	fir_output_checker checker_h = new();

	int   items_sent;
	int   burst_left;
	bit   tx_gaps_on;
	bit   hold_req;
	bit   hold_done;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout, %0d outputs still expected", $time, checker_h.pending());
		$display("Simulation FAILED");
		$finish;
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			checker_h.check_output(filtered_value);
	end

	// Receiver: stall pattern switches among four modes at random
	initial begin : result_sink
		int rx_mode;
		int mode_left;
		out_ready = 1'b0;
		rx_mode   = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				// long hold-off so the block backs up and stalls its input
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					rx_mode   = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ((mode_left % 4) == 0);
					default: out_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Drive one transaction; gaps fall only between bursts
	task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] s,
			input logic [TAP_IDX_W-1:0] t, input logic signed [COEF_W-1:0] c);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (tx_gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 10) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		opcode       <= op;
		sample_value <= s;
		tap_index    <= t;
		coef_value   <= c;
		do @(posedge clk); while (!in_ready);
		checker_h.note_input(op, s, t, c);
	endtask

	// Filter transaction with random unused fields
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		send_item(OP_FILTER, s, TAP_IDX_W'($urandom), COEF_W'($urandom));
		items_sent++;
	endtask

	// Load transaction with random unused sample
	task automatic send_coef(input logic [TAP_IDX_W-1:0] t, input logic signed [COEF_W-1:0] c);
		send_item(OP_LOAD, SAMPLE_W'($urandom), t, c);
		if (t < TAPS)
			items_sent++;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SAMPLE_FULL;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	// Every tap at one value, then a full ring of full-scale samples
	task automatic full_scale_run(input logic signed [COEF_W-1:0] c);
		for (int i = 0; i < TAPS; i++)
			send_coef(TAP_IDX_W'(i), c);
		repeat (RING_DEPTH) send_sample(SAMPLE_FULL);
	endtask

	// Main sequence
	initial begin : stimulus
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_FILTER;
		sample_value = '0;
		tap_index    = '0;
		coef_value   = '0;
		items_sent   = 0;
		burst_left   = 0;
		tx_gaps_on   = 1'b0;
		hold_req     = 1'b0;
		hold_done    = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: zero coefficients, missing slot, tap extremes, sample extremes
		send_sample(SAMPLE_FULL);
		send_coef(TAP_IDX_W'(TAPS), COEF_MAX);
		send_sample(SAMPLE_FULL);
		send_coef(TAP_IDX_W'(TAPS - 1), COEF_MAX);
		send_sample(SAMPLE_FULL);
		send_sample('0);
		send_coef('0, COEF_MIN);
		send_coef(TAP_IDX_W'(15), -18'sd1);
		send_sample(16'd1);
		send_sample(16'h8000);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		send_coef(TAP_IDX_W'(TAPS - 1), COEF_MIN);
		send_sample(SAMPLE_FULL);
		send_coef('0, COEF_MAX);
		send_coef(TAP_IDX_W'(TAPS), COEF_MIN);
		send_coef(TAP_IDX_W'(1), 18'sd1);
		send_sample(SAMPLE_FULL);
		send_sample('0);
		send_coef(TAP_IDX_W'(16), 18'sh0AAAA);
		send_sample(16'h7FFF);
		send_sample(SAMPLE_FULL);

		// random: full-scale runs for the output extremes, then mixed sequences
		tx_gaps_on = 1'b1;
		hold_req   = 1'b1;
		full_scale_run(COEF_MAX);
		full_scale_run(COEF_MIN);
		while (items_sent < ITEM_TARGET) begin
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 39) == 0) begin
				full_scale_run(pick_coef());
			end else begin
				repeat ($urandom_range(0, 4)) begin
					// mostly valid slots, now and then the missing one
					if ($urandom_range(0, 9) == 0)
						send_coef(TAP_IDX_W'(TAPS), pick_coef());
					else
						send_coef(TAP_IDX_W'($urandom_range(0, TAPS - 1)), pick_coef());
				end
				repeat ($urandom_range(1, 40)) send_sample(pick_sample());
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain and let any stray output show up
		while (checker_h.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (checker_h.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/frb_pkg.sv
rtl/core/frb_mem.sv
rtl/core/frb_mac.sv
rtl/core/fir_filter_ring_buffer_top.sv
tb/tb_fir_filter_ring_buffer_top.sv
